[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the track switch sample filter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TSF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, checked outside reset.
`define TSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

[src/tsf_pkg.sv]
// ---------------------------------------------------------------------------
// tsf_pkg
// Types and constants shared by the track switch sample filter.
// ---------------------------------------------------------------------------
package tsf_pkg;

    // Number of track type slots in the selection table
    localparam int TYPE_SLOTS = 256;
    localparam int TYPE_W     = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;

    localparam int TRACK_W = 32;
    localparam int CODE_W  = 8;

    localparam logic [TRACK_W-1:0] NO_TRACK = '1;

    // Function codes of an input transaction
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // Verdict codes
    localparam logic VERDICT_PASS = 1'b0;
    localparam logic VERDICT_DROP = 1'b1;

    typedef enum logic [1:0] {
        MODE_INIT   = 2'd0,
        MODE_NORMAL = 2'd1,
        MODE_SWITCH = 2'd2
    } t_mode;

    // One table entry
    typedef struct packed {
        t_mode              mode;
        logic [TRACK_W-1:0] cur_track;
        logic [TRACK_W-1:0] cur_set;
        logic [TRACK_W-1:0] prev_track;
        logic [TRACK_W-1:0] prev_set;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        mode:       MODE_INIT,
        cur_track:  NO_TRACK,
        cur_set:    '0,
        prev_track: NO_TRACK,
        prev_set:   '0
    };

    // Table write request
    typedef struct packed {
        logic              en;
        logic [TYPE_W-1:0] addr;
        t_entry            data;
    } t_tbl_wr;

endpackage

[src/tsf_in_if.sv]
// ---------------------------------------------------------------------------
// tsf_in_if
// Input channel: sample checks and selection updates.
// ---------------------------------------------------------------------------
interface tsf_in_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [tsf_pkg::CODE_W-1:0]   track_type;
    logic [tsf_pkg::TRACK_W-1:0]  fp_track_id;
    logic [tsf_pkg::TRACK_W-1:0]  as_track_id;
    logic                         flag_unavailable;
    logic                         flag_end_of_stream;
    logic                         flag_switch_start;
    logic                         flag_switch_end;

    modport source (
        output valid, func, track_type, fp_track_id, as_track_id,
               flag_unavailable, flag_end_of_stream, flag_switch_start, flag_switch_end,
        input  ready
    );
    modport sink (
        input  valid, func, track_type, fp_track_id, as_track_id,
               flag_unavailable, flag_end_of_stream, flag_switch_start, flag_switch_end,
        output ready
    );
endinterface

[src/tsf_out_if.sv]
// ---------------------------------------------------------------------------
// tsf_out_if
// Output channel: one verdict per input transaction.
// ---------------------------------------------------------------------------
interface tsf_out_if;
    logic valid;
    logic ready;
    logic verdict;

    modport source (output valid, verdict, input ready);
    modport sink (input valid, verdict, output ready);
endinterface

[src/tsf_table.sv]
// ---------------------------------------------------------------------------
// tsf_table
// Per-type selection table: synchronous memory with registered read data
// and per-entry valid bits so unwritten entries read as their reset value.
// ---------------------------------------------------------------------------
module tsf_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [tsf_pkg::TYPE_W-1:0]  i_rd_addr,
    output tsf_pkg::t_entry             o_rd_data,
    input  tsf_pkg::t_tbl_wr            i_wr
);

    tsf_pkg::t_entry                r_mem [tsf_pkg::TYPE_SLOTS];
    logic [tsf_pkg::TYPE_SLOTS-1:0] r_valid;
    tsf_pkg::t_entry                r_rd_data;
    logic                           r_rd_valid;

    // Write port and registered read data
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Track which entries hold written data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // Substitute the reset value for an entry never written
    assign o_rd_data = r_rd_valid ? r_rd_data : tsf_pkg::ENTRY_RESET;

endmodule

[src/track_switch_sample_filter_top.sv]
// ---------------------------------------------------------------------------
// track_switch_sample_filter_top
// Per-track-type selection filter: adopts selection updates and passes or
// drops samples against the current and previous selected track pair.
// ---------------------------------------------------------------------------
//  Channel   Dir  Handshake             Payload
//  i_in      in   valid/ready           func, track_type, ids, four flags
//  o_out     out  valid/ready           verdict
//  cfg       in   i_cfg_we (no stall)   i_cfg_wdata = audio type code
//
//  Each transaction runs as accept and table read, then evaluate, write
//  back and load the output register. The registered read of the table
//  memory sets this split. Reset (synchronous, active low) marks every
//  table entry unwritten. A result held in the output register stalls
//  evaluation of the next one.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module track_switch_sample_filter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tsf_in_if.sink                      i_in,
    tsf_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [tsf_pkg::CODE_W-1:0]  i_cfg_wdata
);

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } t_state;

    t_state                        r_state;
    logic                          r_out_valid;
    logic                          r_verdict;
    logic [tsf_pkg::CODE_W-1:0]    r_audio_code;

    logic                          r_func;
    logic [tsf_pkg::CODE_W-1:0]    r_type;
    logic [tsf_pkg::TRACK_W-1:0]   r_trk;
    logic [tsf_pkg::TRACK_W-1:0]   r_set;
    logic                          r_unavail;
    logic                          r_eos;
    logic                          r_start;
    logic                          r_end;

    logic                          in_accept;
    logic                          n_done;
    logic                          upd_done;
    logic                          n_verdict;
    logic                          in_range;
    logic                          cur_hit;
    logic                          prev_hit;
    tsf_pkg::t_mode                n_mode;
    tsf_pkg::t_entry               rd_entry;
    tsf_pkg::t_tbl_wr              tbl_wr;

    assign i_in.ready    = (r_state == S_IDLE);
    assign in_accept     = i_in.valid && i_in.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.verdict = r_verdict;

    // Finish evaluation once the output register can take the result
    assign n_done   = (r_state == S_LOOK) && (!r_out_valid || o_out.ready);
    assign upd_done = n_done && (r_func == tsf_pkg::FUNC_UPDATE);

    tsf_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_in.track_type[tsf_pkg::TYPE_W-1:0]),
        .o_rd_data (rd_entry),
        .i_wr      (tbl_wr)
    );

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func    <= i_in.func;
            r_type    <= i_in.track_type;
            r_trk     <= i_in.fp_track_id;
            r_set     <= i_in.as_track_id;
            r_unavail <= i_in.flag_unavailable;
            r_eos     <= i_in.flag_end_of_stream;
            r_start   <= i_in.flag_switch_start;
            r_end     <= i_in.flag_switch_end;
        end
    end

    // Evaluate the entry and build the write-back
    always_comb begin
        in_range = ({1'b0, r_type} < (tsf_pkg::CODE_W + 1)'(tsf_pkg::TYPE_SLOTS));
        cur_hit  = (rd_entry.cur_track == r_trk) && (rd_entry.cur_set == r_set);
        prev_hit = (rd_entry.prev_track == r_trk) && (rd_entry.prev_set == r_set);

        n_mode = rd_entry.mode;
        if (r_start) begin
            n_mode = tsf_pkg::MODE_SWITCH;
        end
        if (r_end) begin
            n_mode = tsf_pkg::MODE_NORMAL;
        end

        tbl_wr.en   = 1'b0;
        tbl_wr.addr = r_type[tsf_pkg::TYPE_W-1:0];
        tbl_wr.data = rd_entry;
        n_verdict   = tsf_pkg::VERDICT_PASS;

        if (r_func == tsf_pkg::FUNC_UPDATE) begin
            if (in_range) begin
                if (rd_entry.mode == tsf_pkg::MODE_INIT) begin
                    tbl_wr.en             = n_done;
                    tbl_wr.data.mode      = tsf_pkg::MODE_NORMAL;
                    tbl_wr.data.cur_track = r_trk;
                    tbl_wr.data.cur_set   = r_set;
                end else if (!cur_hit) begin
                    tbl_wr.en              = n_done;
                    tbl_wr.data.prev_track = rd_entry.cur_track;
                    tbl_wr.data.prev_set   = rd_entry.cur_set;
                    tbl_wr.data.cur_track  = r_trk;
                    tbl_wr.data.cur_set    = r_set;
                end
            end
        end else begin
            priority if (r_unavail || r_eos) begin
                n_verdict = tsf_pkg::VERDICT_PASS;
            end else if (!in_range || rd_entry.mode == tsf_pkg::MODE_INIT) begin
                n_verdict = tsf_pkg::VERDICT_DROP;
            end else begin
                tbl_wr.en        = n_done && (n_mode != rd_entry.mode);
                tbl_wr.data.mode = n_mode;
                unique case (n_mode)
                    tsf_pkg::MODE_SWITCH: begin
                        n_verdict = !(cur_hit || ((r_type != r_audio_code) && prev_hit));
                    end
                    tsf_pkg::MODE_NORMAL: begin
                        n_verdict = !(cur_hit ||
                                      ((rd_entry.prev_track != tsf_pkg::NO_TRACK) &&
                                       (rd_entry.cur_set != rd_entry.prev_set) &&
                                       prev_hit));
                    end
                    default: begin
                        n_verdict = tsf_pkg::VERDICT_DROP;
                    end
                endcase
            end
        end
    end

    // Sequence control, output register and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_verdict    <= tsf_pkg::VERDICT_PASS;
            r_audio_code <= '0;
        end else begin
            if (i_cfg_we) begin
                r_audio_code <= i_cfg_wdata;
            end
            // Load a finished result, else drop the one just taken
            if (n_done) begin
                r_out_valid <= 1'b1;
                r_verdict   <= n_verdict;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (n_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    `TSF_ASSERT_NEXT(a_accept_to_look, i_clk, i_rst_n, in_accept, r_state == S_LOOK)
    `TSF_ASSERT_NEXT(a_done_loads_out, i_clk, i_rst_n, n_done, r_out_valid && r_state == S_IDLE)
    `TSF_ASSERT_IMPL(a_no_write_idle, i_clk, i_rst_n, r_state == S_IDLE, !tbl_wr.en)
    `TSF_ASSERT_IMPL(a_update_passes, i_clk, i_rst_n, upd_done, n_verdict == tsf_pkg::VERDICT_PASS)

endmodule

[tb/sv/track_switch_sample_filter_top_tb.sv]
// ---------------------------------------------------------------------------
// track_switch_sample_filter_top_tb
// Self-checking bench for the track switch sample filter. A scoreboard keeps
// its own copy of the per-type selection table and predicts one verdict per
// input transaction. The bench runs a directed pass over the mode rules and
// then random traffic under four audio type codes, with random stalls on
// both channels.
// ---------------------------------------------------------------------------
module track_switch_sample_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                        func;
        logic [tsf_pkg::CODE_W-1:0]  track_type;
        logic [tsf_pkg::TRACK_W-1:0] fp_track_id;
        logic [tsf_pkg::TRACK_W-1:0] as_track_id;
        logic                        unavail;
        logic                        eos;
        logic                        sw_start;
        logic                        sw_end;
    } t_item;

    // Selection table copy and the queue of verdicts still due
    class track_filter_board;
        tsf_pkg::t_mode              sel_mode   [tsf_pkg::TYPE_SLOTS];
        logic [tsf_pkg::TRACK_W-1:0] cur_track  [tsf_pkg::TYPE_SLOTS];
        logic [tsf_pkg::TRACK_W-1:0] cur_set    [tsf_pkg::TYPE_SLOTS];
        logic [tsf_pkg::TRACK_W-1:0] prev_track [tsf_pkg::TYPE_SLOTS];
        logic [tsf_pkg::TRACK_W-1:0] prev_set   [tsf_pkg::TYPE_SLOTS];
        logic [tsf_pkg::CODE_W-1:0]  audio_code;
        logic                        verdicts_due[$];
        int                          errors;

        function new();
            for (int i = 0; i < tsf_pkg::TYPE_SLOTS; i++) begin
                sel_mode[i]   = tsf_pkg::MODE_INIT;
                cur_track[i]  = tsf_pkg::NO_TRACK;
                cur_set[i]    = '0;
                prev_track[i] = tsf_pkg::NO_TRACK;
                prev_set[i]   = '0;
            end
            audio_code = '0;
            errors     = 0;
        endfunction

        function void set_audio(logic [tsf_pkg::CODE_W-1:0] code);
            audio_code = code;
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        // Apply one transaction to the table and return its verdict
        function logic predict_verdict(t_item it);
            int unsigned t;
            logic        cur_hit;
            logic        prev_hit;
            t = 32'(it.track_type);
            if (it.func == tsf_pkg::FUNC_UPDATE) begin
                if (t < tsf_pkg::TYPE_SLOTS) begin
                    if (sel_mode[t] == tsf_pkg::MODE_INIT) begin
                        sel_mode[t]  = tsf_pkg::MODE_NORMAL;
                        cur_track[t] = it.fp_track_id;
                        cur_set[t]   = it.as_track_id;
                    end else if (cur_track[t] != it.fp_track_id ||
                                 cur_set[t] != it.as_track_id) begin
                        prev_track[t] = cur_track[t];
                        prev_set[t]   = cur_set[t];
                        cur_track[t]  = it.fp_track_id;
                        cur_set[t]    = it.as_track_id;
                    end
                end
                return tsf_pkg::VERDICT_PASS;
            end
            if (it.unavail || it.eos)
                return tsf_pkg::VERDICT_PASS;
            if (t >= tsf_pkg::TYPE_SLOTS)
                return tsf_pkg::VERDICT_DROP;
            if (sel_mode[t] == tsf_pkg::MODE_INIT)
                return tsf_pkg::VERDICT_DROP;
            // End wins over start
            if (it.sw_start)
                sel_mode[t] = tsf_pkg::MODE_SWITCH;
            if (it.sw_end)
                sel_mode[t] = tsf_pkg::MODE_NORMAL;
            cur_hit  = (cur_track[t] == it.fp_track_id) && (cur_set[t] == it.as_track_id);
            prev_hit = (prev_track[t] == it.fp_track_id) && (prev_set[t] == it.as_track_id);
            if (sel_mode[t] == tsf_pkg::MODE_SWITCH) begin
                if (cur_hit || (t != 32'(audio_code) && prev_hit))
                    return tsf_pkg::VERDICT_PASS;
            end else if (sel_mode[t] == tsf_pkg::MODE_NORMAL) begin
                if (cur_hit)
                    return tsf_pkg::VERDICT_PASS;
                if (prev_track[t] != tsf_pkg::NO_TRACK && cur_set[t] != prev_set[t] &&
                    prev_hit)
                    return tsf_pkg::VERDICT_PASS;
            end
            return tsf_pkg::VERDICT_DROP;
        endfunction

        function void note_transaction(t_item it);
            verdicts_due.push_back(predict_verdict(it));
        endfunction

        function void check_verdict(logic verdict);
            logic want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, actual %b", $time, verdict);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (verdict !== want) begin
                $display("%0t: verdict mismatch, expected %b, actual %b",
                         $time, want, verdict);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [tsf_pkg::CODE_W-1:0] cfg_wdata;
    bit   no_idle;

    tsf_in_if  in_if();
    tsf_out_if out_if();

    track_filter_board board;

    track_switch_sample_filter_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Record accepted inputs and check accepted verdicts
    always @(posedge i_clk) begin
        t_item seen;
        if (i_rst_n === 1'b1) begin
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
                seen.func        = in_if.func;
                seen.track_type  = in_if.track_type;
                seen.fp_track_id = in_if.fp_track_id;
                seen.as_track_id = in_if.as_track_id;
                seen.unavail     = in_if.flag_unavailable;
                seen.eos         = in_if.flag_end_of_stream;
                seen.sw_start    = in_if.flag_switch_start;
                seen.sw_end      = in_if.flag_switch_end;
                board.note_transaction(seen);
            end
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
                board.check_verdict(out_if.verdict);
        end
    end

    // Stall the verdict channel at random
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 37);
        end
    end

    function automatic t_item mk_item(logic func, logic [tsf_pkg::CODE_W-1:0] tt,
                                      logic [tsf_pkg::TRACK_W-1:0] trk,
                                      logic [tsf_pkg::TRACK_W-1:0] set,
                                      logic u, logic e, logic s, logic en);
        t_item it;
        it.func        = func;
        it.track_type  = tt;
        it.fp_track_id = trk;
        it.as_track_id = set;
        it.unavail     = u;
        it.eos         = e;
        it.sw_start    = s;
        it.sw_end      = en;
        return it;
    endfunction

    // Draw an id mostly from a small pool so that pairs repeat
    function automatic logic [tsf_pkg::TRACK_W-1:0] pick_id();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 12)
            return $urandom();
        else if (r < 20)
            return tsf_pkg::NO_TRACK;
        else
            return $urandom_range(3);
    endfunction

    // Drive one transaction and hold it until accepted
    task automatic send_item(t_item it);
        if (!no_idle && $urandom_range(99) < 37) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_if.valid              <= 1'b1;
        in_if.func               <= it.func;
        in_if.track_type         <= it.track_type;
        in_if.fp_track_id        <= it.fp_track_id;
        in_if.as_track_id        <= it.as_track_id;
        in_if.flag_unavailable   <= it.unavail;
        in_if.flag_end_of_stream <= it.eos;
        in_if.flag_switch_start  <= it.sw_start;
        in_if.flag_switch_end    <= it.sw_end;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1)
            @(posedge i_clk);
    endtask

    // Drop valid and wait until every verdict is back
    task automatic drain();
        in_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_audio(logic [tsf_pkg::CODE_W-1:0] code);
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        board.set_audio(code);
    endtask

    task automatic run_random(int count, logic [tsf_pkg::CODE_W-1:0] audio, int calm_items);
        t_item       it;
        int unsigned r;
        logic [tsf_pkg::CODE_W-1:0] pool [6];
        pool = '{audio, audio ^ 8'h01, 8'h00, 8'hff, 8'h03, 8'h5a};
        for (int n = 0; n < count; n++) begin
            no_idle = (n < calm_items);
            r = $urandom_range(99);
            if (r < 10) begin
                // Noise: every field at random
                it = mk_item(1'($urandom_range(1)),
                             (tsf_pkg::CODE_W)'($urandom_range(255)),
                             $urandom(), $urandom(),
                             1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                it.func        = ($urandom_range(99) < 30) ? tsf_pkg::FUNC_UPDATE
                                                           : tsf_pkg::FUNC_SAMPLE;
                it.track_type  = ($urandom_range(99) < 90)
                                 ? pool[$urandom_range(5)]
                                 : (tsf_pkg::CODE_W)'($urandom_range(255));
                it.fp_track_id = pick_id();
                it.as_track_id = pick_id();
                it.unavail     = ($urandom_range(99) < 5);
                it.eos         = ($urandom_range(99) < 5);
                it.sw_start    = ($urandom_range(99) < 22);
                it.sw_end      = ($urandom_range(99) < 15);
            end
            send_item(it);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        logic [tsf_pkg::CODE_W-1:0] code;
        board   = new();
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        cfg_we  = 1'b0;
        cfg_wdata = '0;
        in_if.valid              = 1'b0;
        in_if.func               = tsf_pkg::FUNC_SAMPLE;
        in_if.track_type         = '0;
        in_if.fp_track_id        = '0;
        in_if.as_track_id        = '0;
        in_if.flag_unavailable   = 1'b0;
        in_if.flag_end_of_stream = 1'b0;
        in_if.flag_switch_start  = 1'b0;
        in_if.flag_switch_end    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass with audio type 0
        write_audio(8'h00);
        // unselected type drops, unavailable and end of stream pass
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'd3, 32'd10, 32'd1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'd3, 32'd10, 32'd1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'd3, 32'd10, 32'd1, 1'b0, 1'b1, 1'b0, 1'b0));
        // first update leaves init; later updates shift current to previous
        send_item(mk_item(tsf_pkg::FUNC_UPDATE, 8'd3, 32'd10, 32'd1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'd3, 32'd10, 32'd1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_UPDATE, 8'd3, 32'd11, 32'd2, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'd3, 32'd10, 32'd1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_UPDATE, 8'd3, 32'd12, 32'd2, 1'b1, 1'b1, 1'b1, 1'b1));
        // previous pair with equal set in normal mode, then in switching mode
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'd3, 32'd11, 32'd2, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'd3, 32'd11, 32'd2, 1'b0, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'd3, 32'd11, 32'd2, 1'b0, 1'b0, 1'b1, 1'b1));
        // audio type refuses the previous pair while switching
        send_item(mk_item(tsf_pkg::FUNC_UPDATE, 8'd0, 32'd20, 32'd7, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_UPDATE, 8'd0, 32'd21, 32'd8, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'd0, 32'd20, 32'd7, 1'b0, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'd0, 32'd21, 32'd8, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_UPDATE, 8'd0, 32'd21, 32'd8, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'd0, 32'd20, 32'd7, 1'b0, 1'b0, 1'b0, 1'b1));
        // unset previous pair compared as stored while switching, not in normal
        send_item(mk_item(tsf_pkg::FUNC_UPDATE, 8'd9, 32'd30, 32'd3, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'd9, tsf_pkg::NO_TRACK, 32'd0,
                          1'b0, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'd9, tsf_pkg::NO_TRACK, 32'd0,
                          1'b0, 1'b0, 1'b0, 1'b1));
        // extreme ids on the top slot
        send_item(mk_item(tsf_pkg::FUNC_UPDATE, 8'hff, tsf_pkg::NO_TRACK, 32'hffff_ffff,
                          1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'hff, tsf_pkg::NO_TRACK, 32'hffff_ffff,
                          1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_UPDATE, 8'hff, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'hff, tsf_pkg::NO_TRACK, 32'hffff_ffff,
                          1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(tsf_pkg::FUNC_SAMPLE, 8'hff, tsf_pkg::NO_TRACK, 32'hffff_ffff,
                          1'b0, 1'b0, 1'b1, 1'b0));

        // Random phases under several audio codes
        run_random(200, 8'h00, 0);
        drain();
        write_audio(8'hff);
        run_random(200, 8'hff, 0);
        drain();
        code = (tsf_pkg::CODE_W)'($urandom_range(255));
        write_audio(code);
        run_random(200, code, 150);
        drain();
        write_audio(8'h03);
        run_random(150, 8'h03, 0);
        drain();

        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

[track_switch_sample_filter_top.f]
+incdir+src
src/tsf_pkg.sv
src/tsf_in_if.sv
src/tsf_out_if.sv
src/tsf_table.sv
src/track_switch_sample_filter_top.sv
tb/sv/track_switch_sample_filter_top_tb.sv
